// ===== design/cfbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfbm_pkg
// Shared types and constants for the clip-free batch mixer.
// ----------------------------------------------------------------------------
package cfbm_pkg;

  localparam int unsigned BatchDepth = 64;
  localparam int unsigned AddrW      = $clog2(BatchDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned QShift     = 15;
  localparam logic [15:0] GainMax    = 16'd32767;
  localparam int unsigned QueueDepth = 2;

  // request handed from the front part to the back part
  typedef struct packed {
    logic signed [SampleW-1:0] media;
    logic signed [SampleW-1:0] announce;
    logic                      clip;
    logic                      last;
  } cfbm_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } cfbm_bk_state_e;

endpackage

`default_nettype wire

// ===== design/cfbm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfbm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfbm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/cfbm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfbm_front
// Accepts sample pairs, detects clipping, ends the batch when full, and pushes
// classified requests into a small queue for the back part.
// ----------------------------------------------------------------------------
module cfbm_front import cfbm_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [SampleW-1:0] media_sample_i,
  input  wire logic signed [SampleW-1:0] announce_sample_i,
  input  wire logic                      batch_end_i,
  output logic                           req_valid_o,
  output cfbm_req_t                      req_o,
  input  wire logic                      req_pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cfbm_req_t          queue_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]      count_q, count_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic               push;
  logic signed [SampleW:0] sum;
  cfbm_req_t          req_new;

  // classify the incoming pair
  always_comb begin
    sum              = {media_sample_i[SampleW-1], media_sample_i}
                     + {announce_sample_i[SampleW-1], announce_sample_i};
    req_new.media    = media_sample_i;
    req_new.announce = announce_sample_i;
    req_new.clip     = sum[SampleW] != sum[SampleW-1];
    req_new.last     = batch_end_i || (fill_q == CntW'(BatchDepth - 1));
  end

  assign in_stall    = (count_q == (PtrW+1)'(QueueDepth));
  assign push        = in_valid && !in_stall;
  assign req_valid_o = (count_q != '0);
  assign req_o       = queue_q[rd_ptr_q];

  // queue pointers and batch fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      fill_d   = req_new.last ? '0 : fill_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + (PtrW+1)'(push) - (PtrW+1)'(req_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= req_new;
    end
  end

endmodule

`default_nettype wire

// ===== design/cfbm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfbm_div
// Iterative restoring divider: 31-bit numerator by 16-bit denominator, one
// quotient bit per cycle, quotient saturated to the Q15 gain maximum.
// ----------------------------------------------------------------------------
module cfbm_div import cfbm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] num_hi_i,   // numerator is num_hi_i << 15
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [15:0]      gain_o
);

  // quotient < 2^16 iff num_hi < 2*den, always true when den >= |media| ...
  // not guaranteed, so 16 quotient bits are found and overflow checked first
  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] den_q;
  logic [14:0] low_q, low_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, ovf_q, ovf_d;
  logic [17:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    done_o = 1'b0;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      // high part of quotient: num_hi / den >= 2 means quotient >= 2^16
      ovf_d  = (den_i == '0) || ({1'b0, num_hi_i} >= {den_i, 1'b0});
      // preload remainder with num_hi mod den for num_hi < 2*den
      rem_d  = (num_hi_i >= den_i) ? {1'b0, num_hi_i - den_i} : {1'b0, num_hi_i};
      quo_d  = {15'd0, num_hi_i >= den_i};
      low_d  = '0;
      cnt_d  = 5'd15;
    end else if (busy_q) begin
      trial = {rem_q, low_q[14]} - {2'b00, den_q};
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], low_q[14]};
        quo_d = {quo_q[14:0], 1'b0};
      end
      low_d = {low_q[13:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  // saturate: quotient at or beyond 32768 becomes the gain maximum
  always_comb begin
    if (ovf_q || quo_d[15]) gain_o = GainMax;
    else                    gain_o = quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    low_q <= low_d;
    ovf_q <= ovf_d;
    if (start_i) den_q <= den_i;
  end

endmodule

`default_nettype wire

// ===== design/cfbm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfbm_back
// Stores pairs, runs the gain divider for clipping pairs, keeps the batch
// minimum gain and streams the mixed batch out through an output register.
// ----------------------------------------------------------------------------
module cfbm_back import cfbm_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  cfbm_req_t                      req_i,
  output logic                           req_pop_o,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SampleW-1:0]      mixed_sample_o,
  output logic                           last_out_o
);

  cfbm_bk_state_e   state_q, state_d;
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, n_last_q, n_last_d;
  logic [15:0]      gain_q, gain_d;
  logic             clip_q, clip_d, end_q, end_d;
  logic             we;
  logic [15:0]      m_rd, a_rd;
  logic             div_start, div_done;
  logic [15:0]      div_gain, abs_m, abs_a;
  logic [AddrW-1:0] raddr;

  // stage pipeline for the output stream
  logic             rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic             mul_v_q, mul_last_q;
  logic signed [15:0] a_mul_q, m_mul_q;
  logic             ov_q, ov_d;
  logic signed [15:0] ov_data_q, ov_data_d;
  logic             ov_last_q, ov_last_d;
  logic             s1_adv, s2_adv, s3_adv;
  logic signed [31:0] prod;
  logic signed [15:0] res;

  always_comb begin
    abs_m = req_i.media[15]    ? 16'(-req_i.media)    : req_i.media;
    abs_a = req_i.announce[15] ? 16'(-req_i.announce) : req_i.announce;
  end

  cfbm_ram #(.Width(SampleW), .Depth(BatchDepth)) u_media_ram (
    .clk_i, .we_i(we), .waddr_i(wptr_q), .wdata_i(req_i.media),
    .raddr_i(raddr), .rdata_o(m_rd)
  );

  cfbm_ram #(.Width(SampleW), .Depth(BatchDepth)) u_ann_ram (
    .clk_i, .we_i(we), .waddr_i(wptr_q), .wdata_i(req_i.announce),
    .raddr_i(raddr), .rdata_o(a_rd)
  );

  cfbm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_hi_i(16'(17'd32768 - {1'b0, abs_a})), .den_i(abs_m),
    .done_o(div_done), .gain_o(div_gain)
  );

  // pipeline advance: output register, multiply register, read register
  assign s3_adv = !ov_q || !out_stall;
  assign s2_adv = s3_adv || !mul_v_q;
  assign s1_adv = s2_adv || !rd_v_q;

  // control sequencer
  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    n_last_d  = n_last_q;
    gain_d    = gain_q;
    clip_d    = clip_q;
    end_d     = end_q;
    we        = 1'b0;
    req_pop_o = 1'b0;
    div_start = 1'b0;
    rd_v_d    = s1_adv ? 1'b0 : rd_v_q;
    rd_last_d = rd_last_q;
    // a held read stage re-reads its own entry
    raddr     = (rd_v_q && !s1_adv) ? rptr_q - 1'b1 : rptr_q;
    case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          we = 1'b1;
          if (req_i.clip) begin
            div_start = 1'b1;
            clip_d    = 1'b1;
            state_d   = BK_DIV;
          end else begin
            req_pop_o = 1'b1;
            wptr_d    = wptr_q + 1'b1;
            if (req_i.last) begin
              n_last_d = wptr_q;
              rptr_d   = '0;
              state_d  = BK_EMIT;
            end
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (div_gain < gain_q) gain_d = div_gain;
          req_pop_o = 1'b1;
          wptr_d    = wptr_q + 1'b1;
          if (req_i.last) begin
            n_last_d = wptr_q;
            rptr_d   = '0;
            state_d  = BK_EMIT;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_EMIT: begin
        if (mul_v_q && mul_last_q && s2_adv) begin
          // last sample enters the output register, batch state is free
          end_d   = 1'b0;
          state_d = BK_IDLE;
          wptr_d  = '0;
        end else if (s1_adv && !end_q) begin
          rd_v_d    = 1'b1;
          rd_last_d = (rptr_q == n_last_q);
          rptr_d    = rptr_q + 1'b1;
          if (rptr_q == n_last_q) end_d = 1'b1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // mix arithmetic
  always_comb begin
    prod      = m_mul_q * $signed({1'b0, gain_q[14:0]});
    res       = clip_q ? 16'(prod >>> QShift) + a_mul_q : m_mul_q + a_mul_q;
    ov_d      = ov_q && out_stall;
    ov_data_d = ov_data_q;
    ov_last_d = ov_last_q;
    if (s3_adv && mul_v_q) begin
      ov_d      = 1'b1;
      ov_data_d = res;
      ov_last_d = mul_last_q;
    end
  end

  assign out_valid      = ov_q;
  assign mixed_sample_o = ov_data_q;
  assign last_out_o     = ov_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      wptr_q  <= '0;
      rptr_q  <= '0;
      gain_q  <= GainMax;
      clip_q  <= 1'b0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      ov_q    <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      rd_v_q  <= rd_v_d;
      ov_q    <= ov_d;
      end_q   <= end_d;
      if (s2_adv) mul_v_q <= rd_v_q;
      // batch state clears once the last read has passed the multiply stage
      if (mul_v_q && mul_last_q && s2_adv) begin
        gain_q <= GainMax;
        clip_q <= 1'b0;
      end else begin
        gain_q <= gain_d;
        clip_q <= clip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_last_q  <= n_last_d;
    rd_last_q <= rd_last_d;
    ov_data_q <= ov_data_d;
    ov_last_q <= ov_last_d;
    if (s2_adv && rd_v_q) begin
      m_mul_q    <= m_rd;
      a_mul_q    <= a_rd;
      mul_last_q <= rd_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/clip_free_batch_mixer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clip_free_batch_mixer_core
// Batch mixer of media and announcement samples with clip-free media ducking.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with media_sample_i, announce_sample_i
// and batch_end_i. Each pair is stored; a pair whose sum overflows 16 bits
// starts the gain divider, and the batch keeps the smallest Q15 gain.
// A batch ends on batch_end_i or when 64 pairs are stored.
// Output channel: out_valid / out_stall with mixed_sample_o and last_out_o,
// one result per stored pair, last_out_o on the final one.
// In the back part a clipping pair, unlike a non-clipping one, is held until
// the one-bit-per-cycle gain divider is done. After the last pair the batch
// streams out at one sample per cycle while out_stall is low, through the RAM
// read, multiply and output registers.
// A two-entry request queue lets input keep flowing while the back part
// divides. While the batch drains no new pair is stored.
// Reset clears states, pointers, counts, valid bits and gain, not the stores.
// When the receiver stalls, the output register holds its sample and the
// read pipeline stops behind it.
// ----------------------------------------------------------------------------
module clip_free_batch_mixer_core import cfbm_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [SampleW-1:0] media_sample_i,
  input  wire logic signed [SampleW-1:0] announce_sample_i,
  input  wire logic                      batch_end_i,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SampleW-1:0]      mixed_sample_o,
  output logic                           last_out_o
);

  cfbm_req_t req;
  logic      req_valid, req_pop;

  cfbm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .media_sample_i, .announce_sample_i, .batch_end_i,
    .req_valid_o(req_valid), .req_o(req), .req_pop_i(req_pop)
  );

  cfbm_back u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_pop_o(req_pop),
    .out_valid, .out_stall, .mixed_sample_o, .last_out_o
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the clip-free batch mixer: batches of sample pairs go in, and each
// mixed sample that comes out is compared with a local model of the ducking
// gain and the mix.
// ----------------------------------------------------------------------------
module tb_top;
  import cfbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SampleW-1:0] media_sample_i = '0;
  logic signed [SampleW-1:0] announce_sample_i = '0;
  logic batch_end_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SampleW-1:0] mixed_sample_o;
  logic last_out_o;

  typedef struct {
    logic signed [15:0] mixed;
    logic               last;
  } mix_exp_t;

  // model state
  logic signed [15:0] pend_media[$];
  logic signed [15:0] pend_ann[$];
  logic [15:0] batch_gain = GainMax;
  logic        batch_clipped = 1'b0;
  mix_exp_t    mix_expected[$];

  int mismatches = 0;
  int cycles = 0;
  int stall_left = 0;

  always #1 clk_i = ~clk_i;

  clip_free_batch_mixer_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall),
    .media_sample_i(media_sample_i), .announce_sample_i(announce_sample_i),
    .batch_end_i(batch_end_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .mixed_sample_o(mixed_sample_o), .last_out_o(last_out_o)
  );

  // predict results for one accepted request
  task automatic mix_predict(input logic signed [15:0] m, input logic signed [15:0] a,
                             input logic e);
    int sum;
    longint num, den, q, prod;
    mix_exp_t x;
    sum = int'(m) + int'(a);
    pend_media.push_back(m);
    pend_ann.push_back(a);
    if (sum > 32767 || sum < -32768) begin
      num = (longint'(32768) - (a < 0 ? -longint'(a) : longint'(a))) << 15;
      den = m < 0 ? -longint'(m) : longint'(m);
      q = den != 0 ? num / den : 32767;
      if (q > 32767) q = 32767;
      if (q < batch_gain) batch_gain = q[15:0];
      batch_clipped = 1'b1;
    end
    if (!e && pend_media.size() < BatchDepth) return;
    for (int k = 0; k < pend_media.size(); k++) begin
      if (batch_clipped) begin
        prod = longint'(pend_media[k]) * longint'(batch_gain);
        x.mixed = 16'((prod >>> 15) + longint'(pend_ann[k]));
      end else begin
        x.mixed = 16'(int'(pend_media[k]) + int'(pend_ann[k]));
      end
      x.last = (k == pend_media.size() - 1);
      mix_expected.push_back(x);
    end
    pend_media.delete();
    pend_ann.delete();
    batch_gain = GainMax;
    batch_clipped = 1'b0;
  endtask

  // send one request with a random gap
  task automatic send_pair(input logic signed [15:0] m, input logic signed [15:0] a,
                           input logic e);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    media_sample_i <= m;
    announce_sample_i <= a;
    batch_end_i <= e;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    mix_predict(m, a, e);
  endtask

  // receiver draws a random stall after each result that it takes
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    mix_exp_t x;
    cycles <= cycles + 1;
    if (rst_ni && out_valid && !out_stall) begin
      if (mix_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result mixed=%0d last=%0d", mixed_sample_o, last_out_o);
      end else begin
        x = mix_expected.pop_front();
        if (x.mixed !== mixed_sample_o || x.last !== last_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mixed=%0d last=%0d got mixed=%0d last=%0d",
                     x.mixed, x.last, mixed_sample_o, last_out_o);
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    // no clipping, extremes
    send_pair(16'sd32767, -16'sd32768, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b1);
    // single-pair batch
    send_pair(16'sd100, -16'sd200, 1'b1);
    // positive clip and negative clip
    send_pair(16'sd30000, 16'sd10000, 1'b0);
    send_pair(-16'sd30000, -16'sd10000, 1'b0);
    send_pair(16'sd1234, -16'sd4321, 1'b1);
    // quotient saturates: small media, near full-scale announce
    send_pair(16'sd1, 16'sd32767, 1'b0);
    send_pair(-16'sd32768, -16'sd1, 1'b1);
    // media full scale with announce full scale, then small media with full-scale announce
    send_pair(16'sd32767, 16'sd32767, 1'b0);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd5, -16'sd32768, 1'b1);
  endtask

  task automatic test_full_store();
    // batch ends itself after 64 pairs, no batch end flag
    for (int i = 0; i < BatchDepth; i++)
      send_pair(16'($urandom), 16'($urandom), 1'b0);
    send_pair(16'sd5, 16'sd7, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int len;
    logic signed [15:0] m, a;
    sent = 0;
    while (sent < 150) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      if (len > 150 - sent) len = 150 - sent;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: begin m = 16'($urandom); a = 16'($urandom); end
          1: begin m = 16'($urandom_range(16384, 32767));
                   a = 16'($urandom_range(16384, 32767)); end
          2: begin m = -16'($urandom_range(16384, 32767));
                   a = -16'($urandom_range(16384, 32768)); end
          default: begin m = 16'($urandom_range(0, 3) - 1); a = 16'($urandom); end
        endcase
        send_pair(m, a, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_random();
    in_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && mix_expected.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== clip_free_batch_mixer_core.f =====
design/cfbm_pkg.sv
design/cfbm_ram.sv
design/cfbm_front.sv
design/cfbm_div.sv
design/cfbm_back.sv
design/clip_free_batch_mixer_core.sv
sim/tb_top.sv
